// ----- rtl/smwa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smwa_pkg: shared types and codes
// Register indexes, the sequencer state type and a signed divider handshake.
// ----------------------------------------------------------------------------
package smwa_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MV_LOW    = 3'd0,
    REG_MV_HIGH   = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_PHYS_LOW  = 3'd4,
    REG_PHYS_HIGH = 3'd5,
    REG_WEIGHTS   = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_RECIP,
    ST_MAP_FIX,
    ST_CLAMP,
    ST_MED_PUSH,
    ST_MED_TALLY,
    ST_MED_PICK,
    ST_AVG_PUSH,
    ST_AVG_ACC,
    ST_AVG_DIV,
    ST_AVG_WAIT,
    ST_PHYS_MUL,
    ST_PHYS_DIV,
    ST_PHYS_WAIT,
    ST_OUT
  } seq_state_e;

  // Divider operands are 40-bit signed dividend, 24-bit signed divisor.
  localparam int unsigned DivNumW = 40;
  localparam int unsigned DivDenW = 24;

  typedef struct packed {
    logic                      start;
    logic signed [DivNumW-1:0] num;
    logic signed [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/smwa_rank_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smwa_rank_cell: one tap of the median window
// Holds one sample, shifts it to the next cell on push and keeps its rank.
// ----------------------------------------------------------------------------
module smwa_rank_cell #(
  parameter int unsigned CntW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic [15:0]     data_i,
  output logic [15:0]     data_o,
  input  logic [15:0]     probe_i,
  input  logic            probe_later_i,
  input  logic            clr_i,
  input  logic            tally_i,
  output logic [CntW-1:0] rank_o
);
  logic [15:0]     data_q;
  logic [CntW-1:0] rank_q, rank_d;

  // rank counts window entries that sort before this one (ties by position)
  always_comb begin
    rank_d = rank_q;
    if (clr_i) begin
      rank_d = '0;
    end else if (tally_i) begin
      if ((probe_i < data_q) || (probe_i == data_q && !probe_later_i)) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      rank_q <= '0;
    end else begin
      if (shift_i) data_q <= data_i;
      rank_q <= rank_d;
    end
  end

  assign data_o = data_q;
  assign rank_o = rank_q;
endmodule

// ----- rtl/smwa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smwa_div: signed restoring divider
// One quotient bit a cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module smwa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smwa_pkg::div_req_t  req_i,
  output smwa_pkg::div_rsp_t  rsp_o
);
  import smwa_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW:0]   rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW+1:0] diff;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
    diff  = {1'b0, trial} - {2'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.num[DivNumW-1] ? DivNumW'(-req_i.num) : req_i.num;
      den_d  = req_i.den[DivDenW-1] ? DivDenW'(-req_i.den) : req_i.den;
      neg_d  = req_i.num[DivNumW-1] ^ req_i.den[DivDenW-1];
      rem_d  = '0;
      cnt_d  = CntW'(DivNumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DivDenW+1]) begin
        rem_d = diff[DivDenW:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? DivNumW'(-quo_q) : quo_q;
endmodule

// ----- rtl/sensor_median_weighted_average_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_median_weighted_average_chain: sensor conditioning chain
// Map, clamp, median filter, weighted moving average and physical map.
// ----------------------------------------------------------------------------
// One word in, one word out. Each raw sample is mapped to millivolts by a
// multiply with the reciprocal of ADC_MAX, clamped, pushed into a row of
// median cells whose ranks are tallied one probe per cycle, and the median is
// pushed into the average row whose taps are accumulated one per cycle. One
// shared 40-step serial divider serves the weighted average and the physical
// map; each division holds the sequencer until the divider is done. The result
// word is raised in the same cycle that the input is free again. A weight sum
// of zero skips the average division and equal millivolt ends skip the
// physical division. The block takes one word at a time; the result is
// held in its own register until taken, and only a result still waiting
// when the next one is finished holds the sequencer. Write the registers
// only while no word is in flight. There is no clearing pass.
// ----------------------------------------------------------------------------
module sensor_median_weighted_average_chain #(
  parameter int unsigned MEDIAN_TAPS  = 5,
  parameter int unsigned AVERAGE_TAPS = 5,
  parameter int unsigned ADC_MAX      = 1023
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [39:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [9:0]         raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        millivolts_o,
  output logic [15:0]        clamped_millivolts_o,
  output logic [15:0]        median_millivolts_o,
  output logic [15:0]        averaged_millivolts_o,
  output logic signed [15:0] physical_value_o
);
  import smwa_pkg::*;

  localparam int unsigned MedCntW  = $clog2(MEDIAN_TAPS);
  localparam int unsigned AvgCntW0 = $clog2(AVERAGE_TAPS);
  localparam int unsigned AvgCntW  = (AvgCntW0 < 1) ? 1 : AvgCntW0;
  localparam int unsigned MedIdxW  = (MedCntW < 1) ? 1 : MedCntW;
  localparam int unsigned Mid      = MEDIAN_TAPS / 2;
  // reciprocal of ADC_MAX, exact floor division for magnitudes below 2^MagW
  localparam int unsigned MagW     = 26;
  localparam int unsigned RecipW   = 27;
  localparam int unsigned ProdW    = MagW + RecipW;
  localparam int unsigned RecipK   = MagW + $clog2(ADC_MAX);
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << RecipK) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX));

  // configuration registers
  logic [15:0]        mv_low_q, mv_high_q, sat_low_q, sat_high_q;
  logic signed [15:0] phys_low_q, phys_high_q;
  logic [39:0]        weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_low_q    <= 16'd0;
      mv_high_q   <= 16'd5000;
      sat_low_q   <= 16'd0;
      sat_high_q  <= 16'd5000;
      phys_low_q  <= 16'sd0;
      phys_high_q <= 16'sd100;
      weights_q   <= 40'h0101010101;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MV_LOW:    mv_low_q    <= cfg_data_i[15:0];
        REG_MV_HIGH:   mv_high_q   <= cfg_data_i[15:0];
        REG_SAT_LOW:   sat_low_q   <= cfg_data_i[15:0];
        REG_SAT_HIGH:  sat_high_q  <= cfg_data_i[15:0];
        REG_PHYS_LOW:  phys_low_q  <= cfg_data_i[15:0];
        REG_PHYS_HIGH: phys_high_q <= cfg_data_i[15:0];
        REG_WEIGHTS:   weights_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  seq_state_e state_q, state_d;
  logic [MedIdxW-1:0] mcnt_q, mcnt_d;
  logic [AvgCntW-1:0] acnt_q, acnt_d;
  logic [9:0]         raw_q;
  logic signed [39:0] prod_q, prod_d;
  logic [ProdW-1:0]   recip_q, recip_d;
  logic [MagW-1:0]    prod_mag;
  logic [15:0]        mv_q, mv_d, clamp_q, clamp_d, med_q, med_d, avg_q, avg_d;
  logic signed [15:0] phys_q, phys_d;
  logic [39:0]        num_q, num_d;
  logic [15:0]        den_q, den_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [15:0]        out_mv_q, out_clamp_q, out_med_q, out_avg_q;
  logic signed [15:0] out_phys_q;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               med_shift, med_clr, med_tally, avg_shift;

  logic [15:0]        med_data [MEDIAN_TAPS+1];
  logic [MedIdxW-1:0] med_rank [MEDIAN_TAPS];
  logic [15:0]        avg_win_q [AVERAGE_TAPS];
  logic [15:0]        probe;
  logic [15:0]        med_pick;
  logic [7:0]         wsel;
  logic [15:0]        asel;
  logic signed [16:0] mv_span, ph_span;
  logic signed [16:0] map_off;
  logic signed [39:0] map_quo;
  logic signed [39:0] mvsat;
  logic signed [39:0] phsat;

  smwa_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // median row: cell 0 oldest, newest enters at the top
  assign med_data[MEDIAN_TAPS] = clamp_q;
  assign probe = med_data[mcnt_q];

  // a probe at or after a cell's own position does not win a tie
  for (genvar g = 0; g < MEDIAN_TAPS; g++) begin : g_med
    smwa_rank_cell #(.CntW(MedIdxW)) u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(med_shift),
      .data_i(med_data[g+1]), .data_o(med_data[g]),
      .probe_i(probe), .probe_later_i(MedIdxW'(g) <= mcnt_q),
      .clr_i(med_clr), .tally_i(med_tally), .rank_o(med_rank[g])
    );
  end

  always_comb begin
    med_pick = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (med_rank[i] == MedIdxW'(Mid)) med_pick = med_data[i];
    end
  end

  // average row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVERAGE_TAPS; i++) avg_win_q[i] <= '0;
    end else if (avg_shift) begin
      for (int i = 0; i + 1 < AVERAGE_TAPS; i++) avg_win_q[i] <= avg_win_q[i+1];
      avg_win_q[AVERAGE_TAPS-1] <= med_q;
    end
  end

  // select the tap and weight under the accumulation counter
  always_comb begin
    wsel = '0;
    asel = '0;
    for (int k = 0; k < AVERAGE_TAPS; k++) begin
      if (acnt_q == AvgCntW'(k)) begin
        wsel = weights_q[8*k +: 8];
        asel = avg_win_q[k];
      end
    end
  end

  assign mv_span  = $signed({1'b0, mv_high_q}) - $signed({1'b0, mv_low_q});
  assign ph_span  = 17'(phys_high_q) - 17'(phys_low_q);
  assign map_off  = $signed({1'b0, avg_q}) - $signed({1'b0, mv_low_q});
  assign prod_mag = MagW'(prod_q[39] ? -prod_q : prod_q);
  assign map_quo  = 40'(recip_q >> RecipK);
  assign mvsat    = (prod_q[39] ? -map_quo : map_quo) + 40'($signed({1'b0, mv_low_q}));
  assign phsat    = drsp.quo + 40'(phys_low_q);

  always_comb begin
    state_d = state_q; mcnt_d = mcnt_q; acnt_d = acnt_q;
    prod_d = prod_q; recip_d = recip_q; mv_d = mv_q; clamp_d = clamp_q; med_d = med_q;
    avg_d = avg_q; phys_d = phys_q; num_d = num_q; den_d = den_q;
    out_valid_d = out_valid_q;
    out_load = 1'b0;
    dreq = '0;
    med_shift = 1'b0; med_clr = 1'b0; med_tally = 1'b0; avg_shift = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MAP_MUL;
      ST_MAP_MUL: begin
        prod_d  = 40'($signed({1'b0, raw_q}) * mv_span);
        state_d = ST_MAP_RECIP;
      end
      ST_MAP_RECIP: begin
        // divide the magnitude by ADC_MAX; the sign is restored next cycle
        recip_d = ProdW'(prod_mag * RecipM);
        state_d = ST_MAP_FIX;
      end
      ST_MAP_FIX: begin
        // saturate into millivolt range
        if (mvsat < 0) mv_d = '0;
        else if (mvsat > 40'sd65535) mv_d = 16'hFFFF;
        else mv_d = mvsat[15:0];
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (mv_q < sat_low_q) clamp_d = sat_low_q;
        else if (mv_q > sat_high_q) clamp_d = sat_high_q;
        else clamp_d = mv_q;
        med_clr = 1'b1;
        mcnt_d  = '0;
        state_d = ST_MED_PUSH;
      end
      ST_MED_PUSH: begin
        med_shift = 1'b1;
        mcnt_d    = '0;
        state_d   = ST_MED_TALLY;
      end
      ST_MED_TALLY: begin
        // tally one probe a cycle, oldest first
        med_tally = 1'b1;
        if (mcnt_q == MedIdxW'(MEDIAN_TAPS - 1)) begin
          state_d = ST_MED_PICK;
        end else begin
          mcnt_d = mcnt_q + 1'b1;
        end
      end
      ST_MED_PICK: begin
        med_d   = med_pick;
        state_d = ST_AVG_PUSH;
      end
      ST_AVG_PUSH: begin
        avg_shift = 1'b1;
        acnt_d    = '0;
        num_d     = '0;
        den_d     = '0;
        state_d   = ST_AVG_ACC;
      end
      ST_AVG_ACC: begin
        num_d = num_q + 40'(wsel * asel);
        den_d = den_q + 16'(wsel);
        if (acnt_q == AvgCntW'(AVERAGE_TAPS - 1)) begin
          state_d = ST_AVG_DIV;
        end else begin
          acnt_d = acnt_q + 1'b1;
        end
      end
      ST_AVG_DIV: begin
        if (den_q == '0) begin
          avg_d   = '0;
          state_d = ST_PHYS_MUL;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = num_q;
          dreq.den   = 24'(den_q);
          state_d    = ST_AVG_WAIT;
        end
      end
      ST_AVG_WAIT: if (drsp.done) begin
        avg_d   = drsp.quo[15:0];
        state_d = ST_PHYS_MUL;
      end
      ST_PHYS_MUL: begin
        prod_d  = 40'(map_off * ph_span);
        state_d = ST_PHYS_DIV;
      end
      ST_PHYS_DIV: begin
        if (mv_span == '0) begin
          phys_d  = phys_low_q;
          state_d = ST_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = prod_q;
          dreq.den   = 24'(mv_span);
          state_d    = ST_PHYS_WAIT;
        end
      end
      ST_PHYS_WAIT: if (drsp.done) begin
        if (phsat < -40'sd32768) phys_d = 16'sh8000;
        else if (phsat > 40'sd32767) phys_d = 16'sh7FFF;
        else phys_d = phsat[15:0];
        state_d = ST_OUT;
      end
      ST_OUT: if (!out_valid_q || !out_stall_i) begin
        // hand the word to the result register once it is free
        out_valid_d = 1'b1;
        out_load    = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcnt_q      <= '0;
      acnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      acnt_q      <= acnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) raw_q <= raw_sample_i;
    prod_q <= prod_d; recip_q <= recip_d; mv_q <= mv_d; clamp_q <= clamp_d;
    med_q <= med_d; avg_q <= avg_d; phys_q <= phys_d; num_q <= num_d; den_q <= den_d;
    if (out_load) begin
      out_mv_q    <= mv_q;
      out_clamp_q <= clamp_q;
      out_med_q   <= med_q;
      out_avg_q   <= avg_q;
      out_phys_q  <= phys_q;
    end
  end

  assign in_stall_o            = (state_q != ST_IDLE);
  assign out_valid_o           = out_valid_q;
  assign millivolts_o          = out_mv_q;
  assign clamped_millivolts_o  = out_clamp_q;
  assign median_millivolts_o   = out_med_q;
  assign averaged_millivolts_o = out_avg_q;
  assign physical_value_o      = out_phys_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_mv_q)
    && $stable(out_avg_q) && $stable(out_phys_q))
    else $error("result changed while stalled");
`endif
endmodule
